/* hdl/assert_macros.svh */
// assertion macros for the pid step unit rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pid step unit assertion failed");
`define PID_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) not (prop)) \
    else $error("pid step unit forbidden condition seen");
`else
`define PID_ASSERT(lbl, prop)
`define PID_ASSERT_NEVER(lbl, prop)
`endif

`endif

/* hdl/pid_pkg.sv */
// shared constants, config layout, sequencer states and mac request type
// for the pid step unit; no dependencies
package pid_pkg;

  localparam int INTEG_W    = 48;
  localparam int DATA_W     = 32;
  localparam int PERIOD_W   = 24;
  localparam int GAIN_FRAC  = 24;
  localparam int DERIV_FRAC = 16;
  localparam int MUL_A_W    = DATA_W + 1;
  localparam int MUL_B_W    = DATA_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = INTEG_W + 33;
  localparam int IMAG_W     = 2 * DATA_W;
  localparam int TERM_W     = 61;
  localparam int SUM_W      = 63;
  localparam int CFG_IDX_W  = 3;

  // saturation limit of one product term, 2^60
  localparam logic [TERM_W-1:0] TERM_LIM = {1'b1, {(TERM_W-1){1'b0}}};

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_SAMPLE_PERIOD  = 3'd3,
    REG_INVERSE_PERIOD = 3'd4,
    REG_DRIVE_FLOOR    = 3'd5,
    REG_DRIVE_CEILING  = 3'd6
  } cfg_reg_e;

  // gains are kept as sign and magnitude for the unsigned multiplier
  typedef struct packed {
    logic [DATA_W-1:0]        kp_mag;
    logic                     kp_neg;
    logic [DATA_W-1:0]        ki_mag;
    logic                     ki_neg;
    logic [DATA_W-1:0]        kd_mag;
    logic                     kd_neg;
    logic [PERIOD_W-1:0]      period;
    logic [DATA_W-1:0]        inv_period;
    logic signed [DATA_W-1:0] drive_floor;
    logic signed [DATA_W-1:0] drive_ceiling;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    kp_mag:        '0,
    kp_neg:        1'b0,
    ki_mag:        '0,
    ki_neg:        1'b0,
    kd_mag:        '0,
    kd_neg:        1'b0,
    period:        24'd167772,
    inv_period:    32'd6553600,
    drive_floor:   -32'sd16711680,
    drive_ceiling: 32'sd16711680
  };

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD24,
    MAC_LOAD16,
    MAC_ADD_HI
  } mac_op_e;

  typedef struct packed {
    logic [MUL_A_W-1:0] op_a;
    logic [MUL_B_W-1:0] op_b;
    mac_op_e            op;
  } mac_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_INC_ACC,
    ST_INTEG,
    ST_DERIV,
    ST_PTERM,
    ST_ITERM_HI,
    ST_ITERM_ADD,
    ST_ITERM,
    ST_DTERM,
    ST_CLAMP
  } state_e;

endpackage

/* hdl/pid_controller_step_unit.sv */
// top level of the pid step unit: sequencer, controller state and output
// register; uses pid_pkg, pid_cfg, pid_mac and assert_macros.svh
//
// One error sample in, one clamped drive value out. A sample is taken
// only while in_stall_o is low, which is whenever the unit is idle, so a
// new sample is only taken once the last one has passed the clamp step.
// All six products (integrator increment, derivative, three gain terms
// with the integral term split into two halves) go one after another
// through a single registered 33x32 multiplier with a shared accumulator.
// A finished result waits in an output register; the unit goes on
// accepting a new sample and only holds in its last step if the previous
// result has still not been taken. No clearing pass after reset.
`include "assert_macros.svh"

module pid_controller_step_unit import pid_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [DATA_W-1:0] error_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [DATA_W-1:0] drive_value_o,
  output logic                 clamped_o
);

  localparam int IW2   = INTEG_W + 2;
  localparam int DR_W  = ACC_W - DERIV_FRAC;
  localparam int TM_W  = ACC_W - GAIN_FRAC;
  localparam int CMP_W = (TM_W > TERM_W) ? TM_W : TERM_W;

  cfg_t     cfg;
  mac_req_t mac_req;
  logic [ACC_W-1:0] acc;

  state_e state_q, state_d;

  logic [DATA_W-1:0]         e_mag_q;
  logic                      e_neg_q;
  logic signed [DATA_W-1:0]  e_q;
  logic signed [DATA_W-1:0]  last_q;
  logic                      first_q;
  logic [DATA_W:0]           diff_mag_q;
  logic                      diff_neg_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic [IMAG_W-1:0]         imag_q;
  logic                      integ_neg_q;
  logic [DATA_W-1:0]         d_mag_q;
  logic                      d_neg_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic                      out_valid_q;
  logic signed [DATA_W-1:0]  drive_q;
  logic                      clamped_q;

  pid_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pid_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .acc_o (acc)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    mac_req = '{op_a: '0, op_b: '0, op: MAC_HOLD};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        mac_req.op_a = MUL_A_W'(e_mag_q);
        mac_req.op_b = MUL_B_W'(cfg.period);
        state_d      = ST_INC_ACC;
      end
      ST_INC_ACC: begin
        mac_req.op   = MAC_LOAD24;
        mac_req.op_a = diff_mag_q;
        mac_req.op_b = cfg.inv_period;
        state_d      = ST_INTEG;
      end
      ST_INTEG: begin
        mac_req.op   = MAC_LOAD16;
        mac_req.op_a = MUL_A_W'(e_mag_q);
        mac_req.op_b = cfg.kp_mag;
        state_d      = ST_DERIV;
      end
      ST_DERIV: begin
        mac_req.op = MAC_LOAD24;
        state_d    = ST_PTERM;
      end
      ST_PTERM: begin
        mac_req.op_a = MUL_A_W'(imag_q[DATA_W-1:0]);
        mac_req.op_b = cfg.ki_mag;
        state_d      = ST_ITERM_HI;
      end
      ST_ITERM_HI: begin
        mac_req.op   = MAC_LOAD24;
        mac_req.op_a = MUL_A_W'(imag_q[IMAG_W-1:DATA_W]);
        mac_req.op_b = cfg.ki_mag;
        state_d      = ST_ITERM_ADD;
      end
      ST_ITERM_ADD: begin
        mac_req.op   = MAC_ADD_HI;
        mac_req.op_a = MUL_A_W'(d_mag_q);
        mac_req.op_b = cfg.kd_mag;
        state_d      = ST_ITERM;
      end
      ST_ITERM: begin
        mac_req.op = MAC_LOAD24;
        state_d    = ST_DTERM;
      end
      ST_DTERM: begin
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (!(out_valid_q && out_stall_i)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // ---------------- datapath ----------------
  logic [DATA_W-1:0]        in_mag;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          diff_mag;
  logic [DATA_W-1:0]        inc_mag;
  logic signed [IW2-1:0]    inc_s, integ_sum;
  logic signed [INTEG_W-1:0] integ_d;
  logic [INTEG_W-1:0]       integ_mag;
  logic [DR_W-1:0]          deriv_r;
  logic [DATA_W-1:0]        deriv_lim, deriv_mag;
  logic [CMP_W-1:0]         term_ext;
  logic [TERM_W-1:0]        term_mag;
  logic                     term_neg;
  logic signed [SUM_W-1:0]  sum_base, sum_d;
  logic signed [SUM_W-1:0]  lo_ext, hi_ext, v_floor, v_out;

  assign in_mag = error_sample_i[DATA_W-1] ? (~error_sample_i + DATA_W'(1))
                                           : error_sample_i;

  assign diff     = {e_q[DATA_W-1], e_q} - {last_q[DATA_W-1], last_q};
  assign diff_mag = diff[DATA_W] ? (~diff + (DATA_W+1)'(1)) : diff;

  // integrator increment, already rounded in the accumulator
  assign inc_mag   = acc[GAIN_FRAC +: DATA_W];
  assign inc_s     = e_neg_q ? -$signed(IW2'(inc_mag)) : $signed(IW2'(inc_mag));
  assign integ_sum = IW2'(integ_q) + inc_s;

  always_comb begin
    if (integ_sum > IW2'(INTEG_MAX)) begin
      integ_d = INTEG_MAX;
    end else if (integ_sum < IW2'(INTEG_MIN)) begin
      integ_d = INTEG_MIN;
    end else begin
      integ_d = integ_sum[INTEG_W-1:0];
    end
  end

  assign integ_mag = integ_q[INTEG_W-1] ? (~integ_q + INTEG_W'(1)) : integ_q;

  // derivative limited to the signed 32 bit range
  assign deriv_r   = acc[ACC_W-1:DERIV_FRAC];
  assign deriv_lim = diff_neg_q ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  assign deriv_mag = (deriv_r > DR_W'(deriv_lim)) ? deriv_lim : deriv_r[DATA_W-1:0];

  // rounded gain term magnitude, saturated at 2^60
  assign term_ext = CMP_W'(acc[ACC_W-1:GAIN_FRAC]);
  assign term_mag = (term_ext > CMP_W'(TERM_LIM)) ? TERM_LIM : term_ext[TERM_W-1:0];

  always_comb begin
    case (state_q)
      ST_PTERM: term_neg = cfg.kp_neg ^ e_neg_q;
      ST_ITERM: term_neg = cfg.ki_neg ^ integ_neg_q;
      ST_DTERM: term_neg = cfg.kd_neg ^ d_neg_q;
      default:  term_neg = 1'b0;
    endcase
  end

  assign sum_base = (state_q == ST_PTERM) ? '0 : sum_q;
  assign sum_d    = term_neg ? sum_base - $signed(SUM_W'(term_mag))
                             : sum_base + $signed(SUM_W'(term_mag));

  // floor first, then ceiling, so the ceiling wins on inverted limits
  assign lo_ext  = SUM_W'(cfg.drive_floor);
  assign hi_ext  = SUM_W'(cfg.drive_ceiling);
  assign v_floor = (sum_q < lo_ext) ? lo_ext : sum_q;
  assign v_out   = (v_floor > hi_ext) ? hi_ext : v_floor;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      e_q     <= error_sample_i;
      e_mag_q <= in_mag;
      e_neg_q <= error_sample_i[DATA_W-1];
    end
    if (state_q == ST_PREP) begin
      diff_mag_q <= diff_mag;
      diff_neg_q <= diff[DATA_W];
    end
    if (state_q == ST_DERIV) begin
      d_mag_q     <= first_q ? '0 : deriv_mag;
      d_neg_q     <= diff_neg_q;
      imag_q      <= IMAG_W'(integ_mag);
      integ_neg_q <= integ_q[INTEG_W-1];
    end
    if (state_q == ST_PTERM || state_q == ST_ITERM || state_q == ST_DTERM) begin
      sum_q <= sum_d;
    end
    if (state_q == ST_CLAMP && !(out_valid_q && out_stall_i)) begin
      drive_q   <= v_out[DATA_W-1:0];
      clamped_q <= (v_out != sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      integ_q     <= '0;
      last_q      <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INTEG) begin
        integ_q <= integ_d;
      end
      if (state_q == ST_DERIV) begin
        last_q  <= e_q;
        first_q <= 1'b0;
      end
      if (state_q == ST_CLAMP && !(out_valid_q && out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;
  assign clamped_o     = clamped_q;

  `PID_ASSERT(a_accept_starts_seq, (in_valid_i && !in_stall_o) |=> (state_q == ST_PREP))
  `PID_ASSERT(a_first_clears_in_deriv, $fell(first_q) |-> $past(state_q == ST_DERIV))
  `PID_ASSERT(a_result_loaded, (state_q == ST_CLAMP && !(out_valid_q && out_stall_i)) |=> (out_valid_q && state_q == ST_IDLE))
  `PID_ASSERT_NEVER(a_no_first_in_terms, (state_q == ST_PTERM && first_q))

endmodule

/* hdl/pid_cfg.sv */
// configuration register file of the pid step unit
// depends on pid_pkg; stores gains as sign and magnitude
module pid_cfg import pid_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DATA_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t              cfg_q, cfg_d;
  logic [DATA_W-1:0] data_mag;

  assign data_mag = cfg_data_i[DATA_W-1] ? (~cfg_data_i + DATA_W'(1)) : cfg_data_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PROP_GAIN: begin
          cfg_d.kp_mag = data_mag;
          cfg_d.kp_neg = cfg_data_i[DATA_W-1];
        end
        REG_INTEG_GAIN: begin
          cfg_d.ki_mag = data_mag;
          cfg_d.ki_neg = cfg_data_i[DATA_W-1];
        end
        REG_DERIV_GAIN: begin
          cfg_d.kd_mag = data_mag;
          cfg_d.kd_neg = cfg_data_i[DATA_W-1];
        end
        REG_SAMPLE_PERIOD:  cfg_d.period        = cfg_data_i[PERIOD_W-1:0];
        REG_INVERSE_PERIOD: cfg_d.inv_period    = cfg_data_i;
        REG_DRIVE_FLOOR:    cfg_d.drive_floor   = $signed(cfg_data_i);
        REG_DRIVE_CEILING:  cfg_d.drive_ceiling = $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/pid_mac.sv */
// shared multiply-accumulate unit: registered 33x32 unsigned product,
// then an accumulator with rounding preload; depends on pid_pkg
module pid_mac import pid_pkg::*; (
  input  logic             clk_i,
  input  mac_req_t         req_i,
  output logic [ACC_W-1:0] acc_o
);

  localparam logic [ACC_W-1:0] RND24 = ACC_W'(1) << (GAIN_FRAC - 1);
  localparam logic [ACC_W-1:0] RND16 = ACC_W'(1) << (DERIV_FRAC - 1);

  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, acc_d;

  assign prod_d = PROD_W'(req_i.op_a) * PROD_W'(req_i.op_b);

  always_comb begin
    case (req_i.op)
      MAC_LOAD24: acc_d = ACC_W'(prod_q) + RND24;
      MAC_LOAD16: acc_d = ACC_W'(prod_q) + RND16;
      // upper partial product of a wide operand
      MAC_ADD_HI: acc_d = acc_q + (ACC_W'(prod_q) << DATA_W);
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

/* bench/testbench.sv */
// self-checking bench for pid_controller_step_unit: a queue-fed driver, a result checker
// and a bit-exact controller predictor built on pid_pkg
// the bench covers directed corner cases, integrator wind-up and randomized settings
module testbench import pid_pkg::*; ();

  // unmapped register index, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 60;

  typedef struct {
    logic signed [DATA_W-1:0] sample;
    logic signed [DATA_W-1:0] value;
    logic                     clamped;
  } drive_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i = '0;
  logic [DATA_W-1:0]        cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] error_sample_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] drive_value_o;
  logic                     clamped_o;

  // shadow of the configuration registers
  logic signed [DATA_W-1:0] kp_set = '0;
  logic signed [DATA_W-1:0] ki_set = '0;
  logic signed [DATA_W-1:0] kd_set = '0;
  logic [PERIOD_W-1:0]      tick_period = CFG_RST.period;
  logic [DATA_W-1:0]        tick_rate = CFG_RST.inv_period;
  logic signed [DATA_W-1:0] out_low = CFG_RST.drive_floor;
  logic signed [DATA_W-1:0] out_high = CFG_RST.drive_ceiling;

  // controller state as the predictor sees it
  longint                   integ_acc = 0;
  logic signed [DATA_W-1:0] prev_err = '0;
  logic                     fresh_start = 1'b1;

  logic [DATA_W-1:0]        error_backlog[$];
  drive_result_t            expected_drives[$];
  logic [DATA_W-1:0]        drift_err = '0;
  int                       idle_odds = 0;
  int                       mismatches = 0;
  int                       tx_gap = 0;
  int                       rx_gap = 0;
  int                       hold_left = 0;
  int                       quiet_cycles = 0;
  logic                     long_hold_req = 1'b0;
  logic                     long_hold_done = 1'b0;

  pid_controller_step_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .error_sample_i (error_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .drive_value_o  (drive_value_o),
    .clamped_o      (clamped_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // round(a * b / 2^24) half away from zero, magnitude capped at 2^60
  function automatic longint scale_q24(input longint a, input longint b);
    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [63:0]  rounded;
    logic [127:0] prod;
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    prod = {64'd0, mag_a} * {64'd0, mag_b} + (128'd1 << 23);
    if ((prod >> 24) > 128'(TERM_LIM)) begin
      rounded = 64'(TERM_LIM);
    end else begin
      rounded = prod[87:24];
    end
    return ((a < 0) != (b < 0)) ? -$signed(rounded) : $signed(rounded);
  endfunction

  function automatic drive_result_t advance_controller(input logic signed [DATA_W-1:0] err);
    drive_result_t res;
    longint        inc;
    longint        diff;
    longint        slope;
    longint        total;
    longint        held;
    logic [63:0]   mag_diff;
    logic [63:0]   prod;
    logic [63:0]   rounded;
    inc = scale_q24(longint'(err), longint'(tick_period));
    integ_acc = integ_acc + inc;
    if (integ_acc > longint'(INTEG_MAX)) integ_acc = INTEG_MAX;
    if (integ_acc < longint'(INTEG_MIN)) integ_acc = INTEG_MIN;
    if (fresh_start) begin
      slope = 0;
    end else begin
      diff = longint'(err) - longint'(prev_err);
      mag_diff = (diff < 0) ? -diff : diff;
      prod = mag_diff * {32'd0, tick_rate};
      rounded = (prod >> 16) + prod[15];
      if (diff < 0) begin
        slope = (rounded > 64'h8000_0000) ? -64'sd2147483648 : -$signed(rounded);
      end else begin
        slope = (rounded > 64'h7FFF_FFFF) ? 64'sd2147483647 : $signed(rounded);
      end
    end
    fresh_start = 1'b0;
    prev_err = err;
    total = scale_q24(longint'(kp_set), longint'(err)) + scale_q24(longint'(ki_set), integ_acc)
          + scale_q24(longint'(kd_set), slope);
    held = (total < longint'(out_low)) ? longint'(out_low) : total;
    if (held > longint'(out_high)) held = out_high;
    res.sample = err;
    res.value = held[DATA_W-1:0];
    res.clamped = (held != total);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic enqueue_error(input logic [DATA_W-1:0] err);
    error_backlog.insert(error_backlog.size(), err);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PROP_GAIN:      kp_set = data;
      REG_INTEG_GAIN:     ki_set = data;
      REG_DERIV_GAIN:     kd_set = data;
      REG_SAMPLE_PERIOD:  tick_period = data[PERIOD_W-1:0];
      REG_INVERSE_PERIOD: tick_rate = data;
      REG_DRIVE_FLOOR:    out_low = data;
      REG_DRIVE_CEILING:  out_high = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (error_backlog.size() != 0 || expected_drives.size() != 0 || in_valid_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] random_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
    endcase
  endfunction

  // mostly a slowly wandering error as a closed loop would give, the rest noise or corner values
  function automatic logic [DATA_W-1:0] next_error();
    case ($urandom_range(0, 9))
      0, 1: drift_err = $urandom();
      2: drift_err = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      3: begin
        case ($urandom_range(0, 4))
          0: drift_err = 32'h7FFF_FFFF;
          1: drift_err = 32'h8000_0000;
          2: drift_err = '0;
          3: drift_err = 32'h0000_0001;
          default: drift_err = 32'hFFFF_FFFF;
        endcase
      end
      default: drift_err = drift_err + ($urandom_range(0, 32'h0000_4000) - 32'h0000_2000);
    endcase
    return drift_err;
  endfunction

  task automatic pick_settings();
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] tmp;
    write_reg(REG_PROP_GAIN, random_gain());
    write_reg(REG_INTEG_GAIN, random_gain());
    write_reg(REG_DERIV_GAIN, random_gain());
    // junk in the upper byte must be dropped
    write_reg(REG_SAMPLE_PERIOD, ($urandom_range(0, 7) == 0) ? ($urandom() & 32'hFF00_0000)
                                                             : $urandom());
    write_reg(REG_INVERSE_PERIOD, ($urandom_range(0, 2) == 0) ? $urandom()
                                                              : $urandom_range(0, 32'h00FF_FFFF));
    if ($urandom_range(0, 1)) begin
      lo = $urandom();
      hi = $urandom();
    end else begin
      lo = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      hi = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    end
    case ($urandom_range(0, 5))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: ;  // keep whatever order came out, inverted limits included
      default: begin
        if (lo > hi) begin
          tmp = lo;
          lo = hi;
          hi = tmp;
        end
      end
    endcase
    write_reg(REG_DRIVE_FLOOR, lo);
    write_reg(REG_DRIVE_CEILING, hi);
  endtask

  // sender: predicts each accepted beat, holds a stalled beat steady
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_drives.insert(expected_drives.size(), advance_controller(error_sample_i));
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (error_backlog.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
          tx_gap = $urandom_range(0, 2);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          error_sample_i <= error_backlog.pop_front();
        end
      end
    end
  end

  // receiver: checks each result beat and decides the stall for the next cycle
  always @(posedge clk_i) begin : result_check
    drive_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("unexpected result drive %0d", drive_value_o));
        end else begin
          want = expected_drives.pop_front();
          if (drive_value_o !== want.value)
            report_mismatch($sformatf("sample %0d: drive %0d, want %0d",
                                      want.sample, drive_value_o, want.value));
          if (clamped_o !== want.clamped)
            report_mismatch($sformatf("sample %0d: clamp flag %b, want %b",
                                      want.sample, clamped_o, want.clamped));
        end
      end
      if (hold_left == 0 && long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        rx_gap = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_odds = 4;

    // reset settings: gains are zero, only the integrator moves
    error_backlog = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001};
    wait_idle();

    // gains 1, 0.5, 1/16, full-range limits; the second beat saturates the derivative
    write_reg(REG_PROP_GAIN, 32'h0100_0000);
    write_reg(REG_INTEG_GAIN, 32'h0080_0000);
    write_reg(REG_DERIV_GAIN, 32'h0010_0000);
    write_reg(REG_DRIVE_FLOOR, 32'h8000_0000);
    write_reg(REG_DRIVE_CEILING, 32'h7FFF_FFFF);
    write_reg(REG_SPARE, $urandom());
    error_backlog = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                      32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 32'hFFFF_FFFF};
    wait_idle();

    // extreme gains and periods, the derivative saturates
    write_reg(REG_PROP_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_INTEG_GAIN, 32'h8000_0000);
    write_reg(REG_DERIV_GAIN, 32'h8000_0000);
    write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
    write_reg(REG_INVERSE_PERIOD, 32'hFFFF_FFFF);
    error_backlog = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h0000_0000};
    wait_idle();

    // floor above ceiling: the ceiling wins
    write_reg(REG_PROP_GAIN, 32'h0100_0000);
    write_reg(REG_INTEG_GAIN, 32'h0000_0000);
    write_reg(REG_DERIV_GAIN, 32'h0000_0000);
    write_reg(REG_DRIVE_FLOOR, 32'h0010_0000);
    write_reg(REG_DRIVE_CEILING, 32'hFFF0_0000);
    error_backlog = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    wait_idle();

    // zero period freezes the integrator, zero rate kills the derivative
    write_reg(REG_SAMPLE_PERIOD, 32'hFF00_0000);
    write_reg(REG_INVERSE_PERIOD, 32'h0000_0000);
    write_reg(REG_INTEG_GAIN, 32'h0100_0000);
    write_reg(REG_DERIV_GAIN, 32'h0100_0000);
    write_reg(REG_DRIVE_FLOOR, 32'h8000_0000);
    write_reg(REG_DRIVE_CEILING, 32'h7FFF_FFFF);
    error_backlog = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0005};
    wait_idle();

    // push the integrator hard one way and back, the smallest gain keeps it visible
    idle_odds = 0;
    write_reg(REG_PROP_GAIN, 32'h0000_0000);
    write_reg(REG_DERIV_GAIN, 32'h0000_0000);
    write_reg(REG_INTEG_GAIN, 32'h0000_0001);
    write_reg(REG_SAMPLE_PERIOD, 32'h00FF_FFFF);
    for (n = 0; n < 48; n++) enqueue_error(32'h7FFF_FFFF);
    for (n = 0; n < 16; n++) enqueue_error(32'h8000_0000);
    wait_idle();

    for (phase = 0; phase < 6; phase++) begin
      pick_settings();
      case ($urandom_range(0, 3))
        0: idle_odds = 0;
        1: idle_odds = 2;
        2: idle_odds = 5;
        default: idle_odds = 10;
      endcase
      if (phase == 5) idle_odds = 0;
      if (phase == 1) long_hold_req = 1'b1;
      for (n = 0; n < 195; n++) enqueue_error(next_error());
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
